// ===== hw/rtl/dtdc_pkg.sv =====
// shared types, constants and the character decoder for the triplet diversity counter
// no dependencies
package dtdc_pkg;

	localparam int SYMBOL_W = 8;
	localparam int BASE_W   = 2;
	localparam int INDEX_W  = 3 * BASE_W;
	localparam int MASK_W   = 1 << INDEX_W;
	localparam int GROUP_W  = 8;
	localparam int GROUPS   = MASK_W / GROUP_W;
	localparam int GCOUNT_W = $clog2(GROUP_W + 1);
	localparam int COUNT_W  = $clog2(MASK_W + 1);

	typedef logic [BASE_W-1:0]   base_t;
	typedef logic [SYMBOL_W-1:0] symbol_t;
	typedef logic [MASK_W-1:0]   mask_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [GCOUNT_W-1:0] gcount_t;

	typedef struct packed {
		logic  ok;
		base_t code;
	} decoded_t;

	// base letters in code order: A, C, G, T
	localparam symbol_t BASE_LETTERS [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
	localparam symbol_t LOWER_A    = 8'h61;
	localparam symbol_t LOWER_Z    = 8'h7a;
	localparam symbol_t CASE_DELTA = 8'h20;

	// case-insensitive map of one character to a base code
	function automatic decoded_t base_decode(input symbol_t sym);
		symbol_t  c;
		decoded_t d;
		c = sym;
		if (c >= LOWER_A && c <= LOWER_Z) begin
			c = c - CASE_DELTA;
		end
		d = '{ok: 1'b0, code: '0};
		for (int k = 0; k < 4; k++) begin
			if (!d.ok && c == BASE_LETTERS[k]) begin
				d.ok   = 1'b1;
				d.code = base_t'(k);
			end
		end
		return d;
	endfunction

endpackage

// ===== hw/rtl/dtdc_if.sv =====
// channel interfaces: character stream in, triplet count out
// depends on dtdc_pkg
interface dtdc_char_if;
	import dtdc_pkg::*;
	logic    valid;
	logic    ready;
	symbol_t symbol;
	logic    last;
	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

interface dtdc_count_if;
	import dtdc_pkg::*;
	logic   valid;
	logic   ready;
	count_t distinct_triplets;
	modport source (output valid, output distinct_triplets, input ready);
	modport sink (input valid, input distinct_triplets, output ready);
endinterface

// ===== hw/rtl/dtdc_popcount.sv =====
// two-stage population count of the presence mask, with the output register
// depends on dtdc_pkg and dtdc_count_if
module dtdc_popcount import dtdc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         mask_valid,
	output logic         mask_ready,
	input  mask_t        mask,
	dtdc_count_if.source result
);

	gcount_t groups_s2 [GROUPS];
	logic    valid_s2;
	logic    move_s2;
	count_t  count_q;
	logic    valid_q;
	count_t  total;

	assign move_s2    = !valid_q || result.ready;
	assign mask_ready = !valid_s2 || move_s2;

	// per-group counts
	always_ff @(posedge clk) begin
		if (mask_valid && mask_ready) begin
			for (int g = 0; g < GROUPS; g++) begin
				groups_s2[g] <= gcount_t'($countones(mask[g*GROUP_W +: GROUP_W]));
			end
		end
	end

	always_comb begin
		total = '0;
		for (int g = 0; g < GROUPS; g++) begin
			total = total + count_t'(groups_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (mask_ready) begin
				valid_s2 <= mask_valid;
			end
			if (move_s2) begin
				valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2 && valid_s2) begin
			count_q <= total;
		end
	end

	assign result.valid             = valid_q;
	assign result.distinct_triplets = count_q;

endmodule

// ===== hw/rtl/dna_triplet_diversity_counter.sv =====
// top level of the distinct trinucleotide counter
// depends on dtdc_pkg, dtdc_if.sv and dtdc_popcount
//
// Takes one sequence line as ASCII characters, one transaction per character, with last
// set on the final one. A, C, G and T in either case are bases; any other byte breaks
// the run of bases. Every window of three consecutive bases marks its triplet in a
// 64-bit presence mask, and the last character of the line yields one result
// transaction carrying the number of different triplets seen (0 to 64); the block is
// then clear for the next line, so no window spans two lines. Lines under three
// characters give 0. One character is taken every cycle while the mask slot is free or
// being taken by the popcount: the window registers and the mask are updated in the
// cycle a character is accepted. The edge that accepts the last character loads the
// mask register, then the two stages of the population count follow. While the result
// waits for its sink, up to two further line ends can be held before characters stall.
module dna_triplet_diversity_counter import dtdc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dtdc_char_if.sink    char_stream,
	dtdc_count_if.source result
);

	// window state
	base_t    prev_base_q;
	logic     prev_valid_q;
	base_t    prev2_base_q;
	logic     prev2_valid_q;
	mask_t    seen_mask_q;

	// final mask of a finished line, waiting for the popcount
	mask_t    mask_s1;
	logic     valid_s1;
	logic     ready_s1;

	decoded_t dec;
	logic     accept;
	logic     hit;
	mask_t    hit_bit;
	mask_t    next_mask;

	assign dec    = base_decode(char_stream.symbol);
	assign accept = char_stream.valid && char_stream.ready;

	// a triplet forms when this base follows two valid bases
	assign hit       = dec.ok && prev_valid_q && prev2_valid_q;
	assign hit_bit   = hit ? (mask_t'(1) << {dec.code, prev_base_q, prev2_base_q}) : '0;
	assign next_mask = seen_mask_q | hit_bit;

	// mask slot frees when empty or when the popcount takes it
	assign char_stream.ready = !valid_s1 || ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_base_q   <= '0;
			prev_valid_q  <= 1'b0;
			prev2_base_q  <= '0;
			prev2_valid_q <= 1'b0;
			seen_mask_q   <= '0;
			valid_s1      <= 1'b0;
		end else begin
			// a new line end refills the slot, otherwise it empties once taken
			if (accept && char_stream.last) begin
				valid_s1 <= 1'b1;
			end else if (ready_s1) begin
				valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (char_stream.last) begin
					// line ends: hand the mask on and start afresh
					prev_base_q   <= '0;
					prev_valid_q  <= 1'b0;
					prev2_base_q  <= '0;
					prev2_valid_q <= 1'b0;
					seen_mask_q   <= '0;
				end else begin
					// shift the window; an invalid byte leaves a broken slot
					prev2_base_q  <= prev_base_q;
					prev2_valid_q <= prev_valid_q;
					prev_base_q   <= dec.ok ? dec.code : '0;
					prev_valid_q  <= dec.ok;
					seen_mask_q   <= next_mask;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && char_stream.last) begin
			mask_s1 <= next_mask;
		end
	end

	dtdc_popcount u_popcount (
		.clk        (clk),
		.arst_n     (arst_n),
		.mask_valid (valid_s1),
		.mask_ready (ready_s1),
		.mask       (mask_s1),
		.result     (result)
	);

	// a line end leaves the window state clear
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && char_stream.last |=> seen_mask_q == '0 && !prev_valid_q && !prev2_valid_q)
		else $error("window state not cleared after line end");

	// a held mask is not overwritten while it waits
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(mask_s1))
		else $error("pending mask lost or changed");

	// no count can exceed the number of triplet codes
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.distinct_triplets <= count_t'(MASK_W))
		else $error("count out of range");

	// the mask only grows within a line
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !char_stream.last |=> (seen_mask_q & $past(seen_mask_q)) == $past(seen_mask_q))
		else $error("mask bit dropped within a line");

endmodule

// ===== sim/dna_triplet_diversity_counter_tb.sv =====
// testbench for dna_triplet_diversity_counter: random and directed sequence lines,
// results checked against a behavioural predictor held in a small scoreboard class
// depends on dtdc_pkg, dtdc_if.sv and the counter rtl
module dna_triplet_diversity_counter_tb;
	import dtdc_pkg::*;

	// base codes in the order the counter uses to build a triplet index
	typedef enum base_t {BASE_A, BASE_C, BASE_G, BASE_T} nucleotide_e;

	localparam int CHAR_TARGET  = 2000;
	localparam int CYCLE_LIMIT  = 600000;
	// mask register plus two popcount stages, with some margin
	localparam int DRAIN_CYCLES = 8;
	localparam symbol_t CASE_BIT = 8'h20;

	// tracks the window of recent bases and the triplet presence mask of the current
	// line, and keeps the counts still owed by the block in order of line ends
	class triplet_scoreboard;
		base_t  recent_code;
		bit     recent_ok;
		base_t  older_code;
		bit     older_ok;
		mask_t  seen;
		count_t counts_due[$];
		int     errors;

		function new();
			errors = 0;
			clear_line();
		endfunction

		function void clear_line();
			recent_code = BASE_A;
			recent_ok   = 1'b0;
			older_code  = BASE_A;
			older_ok    = 1'b0;
			seen        = '0;
		endfunction

		function int pending();
			return counts_due.size();
		endfunction

		// one accepted character transaction
		function void note_char(symbol_t sym, logic is_last);
			base_t code;
			bit    ok;
			ok   = 1'b1;
			code = BASE_A;
			case (sym)
				"A", "a": code = BASE_A;
				"C", "c": code = BASE_C;
				"G", "g": code = BASE_G;
				"T", "t": code = BASE_T;
				default: ok = 1'b0;
			endcase
			// earliest base in the low bits of the index
			if (ok && recent_ok && older_ok) begin
				seen[{code, recent_code, older_code}] = 1'b1;
			end
			older_code  = recent_code;
			older_ok    = recent_ok;
			recent_code = ok ? code : BASE_A;
			recent_ok   = ok;
			if (is_last) begin
				counts_due.push_back(count_t'($countones(seen)));
				clear_line();
			end
		endfunction

		// one accepted result transaction
		function void check_count(count_t got);
			count_t want;
			if (counts_due.size() == 0) begin
				errors++;
				$error("distinct_triplets: expected none, actual %0d", got);
				return;
			end
			want = counts_due.pop_front();
			if (got !== want) begin
				errors++;
				$error("distinct_triplets: expected %0d, actual %0d", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;	// neither side starts a new idle gap or stall while set
	int   chars_sent;
	int   cycles = 0;

	triplet_scoreboard sb = new();

	dtdc_char_if  char_bus ();
	dtdc_count_if count_bus ();

	dna_triplet_diversity_counter DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_stream (char_bus),
		.result      (count_bus)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle length: mostly short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return $urandom_range(1, 2);
		end
		if (r < 92) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(12, 40);
	endfunction

	function automatic symbol_t base_char(base_t code, bit lower);
		symbol_t letter;
		case (nucleotide_e'(code))
			BASE_A:  letter = "A";
			BASE_C:  letter = "C";
			BASE_G:  letter = "G";
			default: letter = "T";
		endcase
		return lower ? (letter | CASE_BIT) : letter;
	endfunction

	// present one character and hold it until the transaction completes;
	// valid stays high into the next call so back-to-back transfers need no reassertion
	task automatic send_char(input symbol_t sym, input logic is_last);
		int gap;
		gap = (steady || $urandom_range(0, 99) < 65) ? 0 : pick_gap();
		if (gap > 0) begin
			char_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_bus.valid  <= 1'b1;
		char_bus.symbol <= sym;
		char_bus.last   <= is_last;
		do @(posedge clk); while (!char_bus.ready);
		chars_sent++;
	endtask

	task automatic send_text(input string s, input bit ends_line);
		for (int i = 0; i < s.len(); i++) begin
			send_char(symbol_t'(s[i]), ends_line && (i == s.len() - 1));
		end
	endtask

	// every one of the 64 triplets once, in shuffled order, so the count saturates
	task automatic send_full_coverage_line();
		int order [64];
		int j;
		int t;
		for (int i = 0; i < 64; i++) begin
			order[i] = i;
		end
		for (int i = 63; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int k = 0; k < 64; k++) begin
			send_char(base_char(base_t'(order[k]), bit'($urandom_range(0, 1))), 1'b0);
			send_char(base_char(base_t'(order[k] >> 2), bit'($urandom_range(0, 1))), 1'b0);
			send_char(base_char(base_t'(order[k] >> 4), bit'($urandom_range(0, 1))),
				k == 63);
		end
	endtask

	// clean lines dominate; dirty lines, pure noise and saturating lines fill the rest
	task automatic send_random_line();
		int      kind;
		int      len;
		symbol_t sym;
		kind   = $urandom_range(0, 99);
		steady = ($urandom_range(0, 9) == 0);
		if (kind >= 95) begin
			send_full_coverage_line();
			return;
		end
		if (kind >= 85) begin
			len = $urandom_range(1, 10);
		end else if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(41, 200);
		end else begin
			len = $urandom_range(1, 40);
		end
		for (int i = 0; i < len; i++) begin
			if (kind >= 85 || (kind >= 60 && $urandom_range(0, 99) < 15)) begin
				sym = symbol_t'($urandom_range(0, 255));
			end else begin
				sym = base_char(base_t'($urandom_range(0, 3)), bit'($urandom_range(0, 1)));
			end
			send_char(sym, i == len - 1);
		end
	endtask

	// result sink: random stalls, none started while steady
	initial begin : result_sink
		int stall_left;
		stall_left      = 0;
		count_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				count_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				count_bus.ready <= 1'b1;
				if (!steady && $urandom_range(0, 99) < 25) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// both channels sampled at the edge, character side first
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_bus.valid && char_bus.ready) begin
				sb.note_char(char_bus.symbol, char_bus.last);
			end
			if (count_bus.valid && count_bus.ready) begin
				sb.check_count(count_bus.distinct_triplets);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("dna_triplet_diversity_counter_tb: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		char_bus.valid  = 1'b0;
		char_bus.symbol = '0;
		char_bus.last   = 1'b0;
		steady          = 1'b0;
		chars_sent      = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one- and two-character lines give no window
		send_text("A", 1'b1);
		send_text("CG", 1'b1);
		// shortest line with a window, completed by the last character
		send_text("ACG", 1'b1);
		// mixed case
		send_text("aCgT", 1'b1);
		// nul, high bytes and an upper extreme break the run of bases
		send_char(8'h00, 1'b0);
		send_text("TTT", 1'b0);
		send_char(8'h80, 1'b0);
		send_text("GG", 1'b0);
		send_char(8'hff, 1'b0);
		send_text("g", 1'b1);
		// invalid character as the line end
		send_text("ACGT", 1'b0);
		send_char(8'h7f, 1'b1);

		while (chars_sent < CHAR_TARGET) begin
			send_random_line();
		end
		char_bus.valid <= 1'b0;
		steady = 1'b0;

		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("dna_triplet_diversity_counter_tb: PASS");
		end else begin
			$display("dna_triplet_diversity_counter_tb: FAIL");
		end
		$finish;
	end

endmodule
